### rtl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
// no dependencies
package hcbp_pkg;

    localparam int SYM_W  = 9;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 31;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 38;
    localparam int CNT_W  = 6;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_ENCODE = 1'b1
    } t_op;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_code_entry;

    typedef struct packed {
        t_code_entry entry;
        logic        is_end;
    } t_work;

endpackage

### rtl/hcbp_front.sv
// front end: code table memory, load and lookup of symbols
// depends on hcbp_pkg
module hcbp_front #(
    parameter int SYMBOL_COUNT = 257,
    parameter int MAX_CODE_LEN = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [hcbp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]  i_code_length,
    input  logic [hcbp_pkg::CODE_W-1:0] i_code_bits,
    output logic                      o_push,
    output hcbp_pkg::t_work           o_work,
    input  logic                      i_full
);
    import hcbp_pkg::*;

    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LIMIT  = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam logic [LEN_W-1:0] LIMIT_L   = LEN_W'(LIMIT);
    localparam logic [SYM_W-1:0] SYM_COUNT = SYM_W'(SYMBOL_COUNT);
    localparam logic [SYM_W-1:0] END_SYM   = SYM_W'(SYMBOL_COUNT - 1);

    t_code_entry       r_mem [SYMBOL_COUNT];
    t_code_entry       r_rd_data;
    logic              r_s1_valid;
    logic              r_s1_end;
    logic              n_s1_valid;
    logic              accept;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len_c;
    logic [CODE_W-1:0] code_c;

    assign o_stall  = r_s1_valid && i_full;
    assign accept   = i_valid && !o_stall;
    assign in_range = i_symbol < SYM_COUNT;
    assign addr     = i_symbol[ADDR_W-1:0];
    assign len_c    = (i_code_length > LIMIT_L) ? LIMIT_L : i_code_length;
    assign code_c   = i_code_bits & ~({CODE_W{1'b1}} << len_c);

    assign o_push = r_s1_valid && !i_full;
    assign o_work = '{entry: r_rd_data, is_end: r_s1_end};

    always_ff @(posedge i_clk) begin
        if (accept && in_range && (t_op'(i_op) == OP_LOAD)) begin
            r_mem[addr] <= '{len: len_c, code: code_c};
        end
        if (accept && in_range && (t_op'(i_op) == OP_ENCODE)) begin
            r_rd_data <= r_mem[addr];
            r_s1_end  <= (i_symbol == END_SYM);
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_push) begin
            n_s1_valid = 1'b0;
        end
        if (accept && in_range && (t_op'(i_op) == OP_ENCODE)) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

endmodule

### rtl/hcbp_queue.sv
// two-entry queue of looked-up codes between front and back
// depends on hcbp_pkg
module hcbp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hcbp_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output hcbp_pkg::t_work o_work,
    output logic            o_empty
);
    import hcbp_pkg::*;

    t_work       r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_work  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/hcbp_back.sv
// back end: pending bit register, byte packing, flush and output register
// depends on hcbp_pkg
module hcbp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcbp_pkg::t_work i_work,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_stream_end
);
    import hcbp_pkg::*;

    localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(BYTE_W);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [PEND_W-1:0] r_bits;
    logic [PEND_W-1:0] n_bits;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_is_end;
    logic              n_is_end;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [7:0]        r_byte;
    logic [7:0]        n_byte;
    logic              r_last;
    logic              n_last;
    logic              r_end;
    logic              n_end;
    logic              slot_free;
    logic [CNT_W-1:0]  rem;
    logic              more;

    assign slot_free     = !r_out_valid || !i_stall;
    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_stream_end  = r_end;

    assign rem  = r_cnt - BYTE_CNT;
    assign more = (rem >= BYTE_CNT) || (r_is_end && (rem != '0));

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_is_end    = r_is_end;
        n_out_valid = r_out_valid && i_stall;
        n_byte      = r_byte;
        n_last      = r_last;
        n_end       = r_end;
        o_pop       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_bits   = r_bits | ({{(PEND_W - CODE_W){1'b0}}, i_work.entry.code}
                               << r_cnt[2:0]);
                    n_cnt    = r_cnt + {1'b0, i_work.entry.len};
                    n_is_end = i_work.is_end;
                    n_state  = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (r_cnt >= BYTE_CNT) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_byte      = r_bits[7:0];
                        n_last      = !more;
                        n_end       = !more && r_is_end;
                        n_bits      = r_bits >> BYTE_W;
                        n_cnt       = rem;
                        if (!more) begin
                            n_state = BK_IDLE;
                        end
                    end
                end else if (r_is_end && (r_cnt != '0)) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_byte      = r_bits[7:0];
                        n_last      = 1'b1;
                        n_end       = 1'b1;
                        n_bits      = '0;
                        n_cnt       = '0;
                        n_state     = BK_IDLE;
                    end
                end else begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_end    <= n_end;
        r_is_end <= n_is_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_bits      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bits      <= n_bits;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/huffman_code_bit_packer.sv
// top level of the huffman code bit packer: front, queue and back
// depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back
//
//   channel | handshake          | payload
//   in      | i_valid / o_stall  | i_op, i_symbol, i_code_length, i_code_bits
//   out     | o_valid / i_stall  | o_out_byte, o_last_of_run, o_stream_end
//
// a load writes the code table in the front; an encode passes the table read register and
// the queue, then the back merges the code in its idle state and, in its emit state, emits
// 1 to 5 bytes, one per cycle unless the output stalls, or goes back to idle when none is due
// the first byte reaches the output register after the table read register, queue and pending bits
// the back sets the rate: it pops a new code only once its emit state has finished the last one
// reset clears control state and the pending bits only; the code table holds nothing until loaded
// a stalled output holds the back, the queue fills, then the input stalls
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = 257,
    parameter int MAX_CODE_LEN = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [hcbp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]  i_code_length,
    input  logic [hcbp_pkg::CODE_W-1:0] i_code_bits,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_out_byte,
    output logic                        o_last_of_run,
    output logic                        o_stream_end
);
    import hcbp_pkg::*;

    t_work q_in;
    t_work q_out;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    hcbp_front #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_symbol     (i_symbol),
        .i_code_length(i_code_length),
        .i_code_bits  (i_code_bits),
        .o_push       (q_push),
        .o_work       (q_in),
        .i_full       (q_full)
    );

    hcbp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_work (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_work (q_out),
        .o_empty(q_empty)
    );

    hcbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (q_out),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_stream_end (o_stream_end)
    );

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_end |-> o_last_of_run)
        else $error("stream end flagged on a byte that is not last of run");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("queue read while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule

### verif/hcbp_checker.sv
// result checker for the huffman code bit packer: watches both channels,
// predicts the packed bytes from each accepted transaction and compares them
// depends on hcbp_pkg
module hcbp_checker #(
    parameter int SYMBOL_COUNT = 257,
    parameter int MAX_CODE_LEN = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_op,
    input  logic [hcbp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]  i_code_length,
    input  logic [hcbp_pkg::CODE_W-1:0] i_code_bits,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [7:0]                  i_out_byte,
    input  logic                        i_last_of_run,
    input  logic                        i_stream_end,
    output int                          o_fail_count,
    output int                          o_outstanding
);
    import hcbp_pkg::*;

    localparam int END_SYMBOL = SYMBOL_COUNT - 1;
    localparam int LEN_LIMIT  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_end;
    } t_packed_byte;

    logic [LEN_W-1:0]  code_len [SYMBOL_COUNT];
    logic [CODE_W-1:0] code_val [SYMBOL_COUNT];
    logic [63:0]       bit_fifo;
    int unsigned       bit_count;
    t_packed_byte      expected_bytes [$];
    int                fail_count;

    task automatic load_code(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                             input logic [CODE_W-1:0] bits);
        int unsigned len_sat;
        logic [63:0] mask;
        len_sat = (len > LEN_LIMIT) ? LEN_LIMIT : len;
        mask = (64'd1 << len_sat) - 64'd1;
        code_len[sym] = LEN_W'(len_sat);
        code_val[sym] = bits & mask[CODE_W-1:0];
    endtask

    task automatic pack_symbol(input logic [SYM_W-1:0] sym);
        logic [63:0]  code;
        int unsigned  len;
        int unsigned  nbytes;
        logic         is_end;
        t_packed_byte item;
        len = (code_len[sym] > LEN_LIMIT) ? LEN_LIMIT : code_len[sym];
        code = 64'(code_val[sym]) & ((64'd1 << len) - 64'd1);
        bit_fifo = bit_fifo | (code << bit_count);
        bit_count = bit_count + len;
        is_end = (sym == END_SYMBOL);
        nbytes = bit_count / 8 + ((is_end && (bit_count % 8 != 0)) ? 1 : 0);
        for (int k = 0; k < nbytes; k++) begin
            item.out_byte    = bit_fifo[7:0];
            item.last_of_run = (k == nbytes - 1);
            item.stream_end  = (k == nbytes - 1) && is_end;
            expected_bytes.push_back(item);
            bit_fifo = bit_fifo >> 8;
        end
        if (is_end) begin
            bit_fifo  = '0;
            bit_count = 0;
        end else begin
            bit_count = bit_count % 8;
        end
        bit_fifo = bit_fifo & ((64'd1 << PEND_W) - 64'd1);
    endtask

    task automatic check_byte();
        t_packed_byte want;
        if (expected_bytes.size() == 0) begin
            if (fail_count < 10)
                $display("%0t: unexpected byte %02h last %0b end %0b", $realtime,
                         i_out_byte, i_last_of_run, i_stream_end);
            fail_count++;
        end else begin
            want = expected_bytes.pop_front();
            if (want.out_byte !== i_out_byte || want.last_of_run !== i_last_of_run ||
                want.stream_end !== i_stream_end) begin
                if (fail_count < 10)
                    $display("%0t: byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                             $realtime, want.out_byte, want.last_of_run, want.stream_end,
                             i_out_byte, i_last_of_run, i_stream_end);
                fail_count++;
            end
        end
    endtask

    initial begin
        fail_count    = 0;
        bit_fifo      = '0;
        bit_count     = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_len[s] = '0;
            code_val[s] = '0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bit_fifo  = '0;
            bit_count = 0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_byte();
            // out-of-range symbols are dropped by the block
            if (i_in_valid && !i_in_stall && i_symbol < SYMBOL_COUNT) begin
                if (t_op'(i_op) == OP_LOAD)
                    load_code(i_symbol, i_code_length, i_code_bits);
                else
                    pack_symbol(i_symbol);
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_bytes.size();
    end

endmodule

### verif/testbench.sv
// top of the huffman code bit packer testbench: clock, reset, stimulus and verdict
// depends on hcbp_pkg, huffman_code_bit_packer and hcbp_checker
module testbench;
    import hcbp_pkg::*;

    localparam int SYMBOL_COUNT = 257;
    localparam int MAX_CODE_LEN = 31;
    localparam int END_SYMBOL   = SYMBOL_COUNT - 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 34;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic              i_op          = 1'b0;
    logic [SYM_W-1:0]  i_symbol      = '0;
    logic [LEN_W-1:0]  i_code_length = '0;
    logic [CODE_W-1:0] i_code_bits   = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_last_of_run;
    logic              o_stream_end;

    int fail_count;
    int outstanding;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    bit loaded [SYMBOL_COUNT];

    huffman_code_bit_packer #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_symbol(i_symbol),
        .i_code_length(i_code_length), .i_code_bits(i_code_bits),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_byte(o_out_byte), .o_last_of_run(o_last_of_run),
        .o_stream_end(o_stream_end)
    );

    hcbp_checker #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_op(i_op), .i_symbol(i_symbol),
        .i_code_length(i_code_length), .i_code_bits(i_code_bits),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_byte(o_out_byte), .i_last_of_run(o_last_of_run),
        .i_stream_end(o_stream_end),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(input t_op op, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_op          <= op;
        i_symbol      <= sym;
        i_code_length <= len;
        i_code_bits   <= bits;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (op == OP_LOAD && sym < SYMBOL_COUNT)
            loaded[sym] = 1'b1;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        return ($urandom_range(1) == 0) ? LEN_W'($urandom_range(31)) :
                                          LEN_W'($urandom_range(10, 1));
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        return ($urandom_range(3) == 0) ? SYM_W'($urandom_range(255)) :
                                          SYM_W'($urandom_range(15));
    endfunction

    task automatic send_random_item();
        int               pick;
        logic [SYM_W-1:0] sym;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_item(t_op'($urandom_range(1)), SYM_W'($urandom_range(511, SYMBOL_COUNT)),
                      LEN_W'($urandom), CODE_W'($urandom));
        end else if (pick < 25) begin
            sym = (pick < 6) ? SYM_W'(END_SYMBOL) : pick_symbol();
            send_item(OP_LOAD, sym, pick_length(), CODE_W'($urandom));
        end else begin
            sym = (pick < 35) ? SYM_W'(END_SYMBOL) : pick_symbol();
            // never encode a symbol whose code has not been loaded
            if (loaded[sym])
                send_item(OP_ENCODE, sym, LEN_W'($urandom), CODE_W'($urandom));
            else
                send_item(OP_LOAD, sym, pick_length(), CODE_W'($urandom));
        end
    endtask

    initial begin
        for (int s = 0; s < SYMBOL_COUNT; s++)
            loaded[s] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-length code, zero-length code with stray bits, single-bit code
        send_item(OP_LOAD,   9'd0,   5'd31, 31'h7FFF_FFFF);
        send_item(OP_ENCODE, 9'd0,   5'd0,  31'h0);
        send_item(OP_LOAD,   9'd255, 5'd0,  31'h55);
        send_item(OP_ENCODE, 9'd255, 5'd31, 31'h7FFF_FFFF);
        send_item(OP_LOAD,   9'd1,   5'd1,  31'h7FFF_FFFE);
        send_item(OP_ENCODE, 9'd1,   5'd0,  31'h0);
        // end of stream with nothing pending, then with a partial byte
        send_item(OP_LOAD,   9'(END_SYMBOL), 5'd0, 31'h0);
        send_item(OP_ENCODE, 9'(END_SYMBOL), 5'd0, 31'h0);
        send_item(OP_LOAD,   9'd2,   5'd5,  31'h15);
        send_item(OP_ENCODE, 9'd2,   5'd0,  31'h0);
        send_item(OP_ENCODE, 9'(END_SYMBOL), 5'd0, 31'h0);
        // longest burst: four full bytes and a padded one
        send_item(OP_LOAD,   9'(END_SYMBOL), 5'd31, 31'h2AAA_AAAA);
        send_item(OP_ENCODE, 9'd2,   5'd0,  31'h0);
        send_item(OP_ENCODE, 9'(END_SYMBOL), 5'd0, 31'h0);
        // symbols out of range
        send_item(OP_LOAD,   9'd511, 5'd31, 31'h7FFF_FFFF);
        send_item(OP_ENCODE, 9'd300, 5'd0,  31'h0);
        send_item(OP_LOAD,   9'd257, 5'd8,  31'h5A);
        send_item(OP_ENCODE, 9'd511, 5'd31, 31'h7FFF_FFFF);
        // all-zero code, end code that yields exactly one full byte
        send_item(OP_LOAD,   9'd170, 5'd16, 31'h0);
        send_item(OP_ENCODE, 9'd170, 5'd0,  31'h0);
        send_item(OP_LOAD,   9'(END_SYMBOL), 5'd8, 31'h7FFF_FFA5);
        send_item(OP_ENCODE, 9'(END_SYMBOL), 5'd0, 31'h0);
        send_item(OP_LOAD,   9'd3,   5'd0,  31'h0);
        send_item(OP_ENCODE, 9'd3,   5'd0,  31'h0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
